// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL; mexp_datapath.sv is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define MEXP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg)

`define MEXP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int FIELD_W   = 32;
    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);

    typedef logic [FIELD_W-1:0]   t_field;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_MULA,
        S_WBA,
        S_MULS,
        S_WBS,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_REDUCE,
        DP_MUL_INIT,
        DP_SQR_INIT,
        DP_MUL_STEP,
        DP_ACC_WB,
        DP_PW_WB,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        logic m_small;
        logic step_last;
        logic exp_bit;
        logic ebit_done;
        logic out_free;
    } t_dp_stat;

    // Sum of two residues below m, reduced by m without overflow.
    function automatic t_word add_mod(input t_word a, input t_word b, input t_word m);
        t_word gap;
        gap = m - b;
        return (a >= gap) ? (a - gap) : (a + b);
    endfunction

endpackage

// ===== sv/mexp_datapath.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mexp_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  mexp_pkg::t_field  i_cfg_data,
    input  mexp_pkg::t_field  i_base_value,
    input  mexp_pkg::t_field  i_exponent,
    input  logic              i_out_stall,
    input  mexp_pkg::t_dp_op  i_cmd,
    output mexp_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output mexp_pkg::t_field  o_power_residue
);
    import mexp_pkg::*;

    t_word  r_modulus;
    t_word  r_base;
    t_word  r_exp;
    t_word  r_acc;
    t_word  r_pw;
    t_word  r_mf;
    t_word  r_mb;
    t_word  r_mp;
    t_word  r_res;
    t_cnt   r_step;
    t_cnt   r_ebit;
    logic   r_out_valid;

    logic              m_small;
    logic [WORD_BITS:0] rem_shift;
    logic [WORD_BITS:0] rem_next;

    assign m_small   = (r_modulus <= t_word'(1));
    assign rem_shift = {r_pw, r_base[WORD_BITS-1]};
    assign rem_next  = (rem_shift >= {1'b0, r_modulus}) ?
                       (rem_shift - {1'b0, r_modulus}) : rem_shift;

    assign o_stat.m_small   = m_small;
    assign o_stat.step_last = (r_step == t_cnt'(WORD_BITS - 1));
    assign o_stat.exp_bit   = r_exp[0];
    assign o_stat.ebit_done = (r_ebit == t_cnt'(WORD_BITS));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= t_word'(1);
        end else if (i_cfg_we) begin
            r_modulus <= t_word'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == DP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_ebit      <= '0;
        end else begin
            unique case (i_cmd)
                DP_LOAD: begin
                    r_step <= '0;
                    r_ebit <= '0;
                end
                DP_REDUCE, DP_MUL_STEP: begin
                    r_step <= r_step + t_cnt'(1);
                end
                DP_MUL_INIT, DP_SQR_INIT, DP_ACC_WB: begin
                    r_step <= '0;
                end
                DP_PW_WB: begin
                    r_ebit <= r_ebit + t_cnt'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_LOAD: begin
                r_base <= t_word'(i_base_value);
                r_exp  <= t_word'(i_exponent);
                r_acc  <= t_word'(1);
                r_pw   <= '0;
            end
            DP_REDUCE: begin
                r_pw   <= rem_next[WORD_BITS-1:0];
                r_base <= {r_base[WORD_BITS-2:0], 1'b0};
            end
            DP_MUL_INIT: begin
                r_mf <= r_acc;
                r_mb <= r_pw;
                r_mp <= '0;
            end
            DP_SQR_INIT: begin
                r_mf <= r_pw;
                r_mb <= r_pw;
                r_mp <= '0;
            end
            DP_MUL_STEP: begin
                if (r_mb[0]) begin
                    r_mp <= add_mod(r_mp, r_mf, r_modulus);
                end
                r_mf <= add_mod(r_mf, r_mf, r_modulus);
                r_mb <= {1'b0, r_mb[WORD_BITS-1:1]};
            end
            DP_ACC_WB: begin
                r_acc <= r_mp;
                r_mf  <= r_pw;
                r_mb  <= r_pw;
                r_mp  <= '0;
            end
            DP_PW_WB: begin
                r_pw  <= r_mp;
                r_exp <= {1'b0, r_exp[WORD_BITS-1:1]};
            end
            DP_RESULT: begin
                r_res <= m_small ? '0 : r_acc;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_power_residue = t_field'(r_res);

    `MEXP_ASSERT(a_mul_residues, i_clk, i_rst_n, (i_cmd == DP_MUL_STEP) |-> (!m_small && r_mp < r_modulus && r_mf < r_modulus), "multiplier operand not reduced")
    `MEXP_ASSERT(a_result_slot, i_clk, i_rst_n, (i_cmd == DP_RESULT) |-> (!r_out_valid || !i_out_stall), "result written over a waiting word")
    `MEXP_ASSERT(a_ebit_range, i_clk, i_rst_n, r_ebit <= t_cnt'(WORD_BITS), "exponent bit count overrun")
    `MEXP_ASSERT(a_step_range, i_clk, i_rst_n, r_step <= t_cnt'(WORD_BITS), "step count overrun")

endmodule

// ===== sv/mexp_control.sv =====
`timescale 1ns / 1ps

module mexp_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mexp_pkg::t_dp_stat i_stat,
    output logic               o_in_stall,
    output mexp_pkg::t_dp_op   o_cmd
);
    import mexp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.m_small ? S_FINISH : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_stat.step_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.ebit_done) begin
                    n_state = S_FINISH;
                end else if (i_stat.exp_bit) begin
                    n_state = S_MULA;
                end else begin
                    n_state = S_MULS;
                end
            end
            S_MULA: begin
                if (i_stat.step_last) begin
                    n_state = S_WBA;
                end
            end
            S_WBA: begin
                n_state = S_MULS;
            end
            S_MULS: begin
                if (i_stat.step_last) begin
                    n_state = S_WBS;
                end
            end
            S_WBS: begin
                n_state = S_CHECK;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = DP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd = DP_LOAD;
                end
            end
            S_REDUCE: begin
                o_cmd = DP_REDUCE;
            end
            S_CHECK: begin
                if (i_stat.ebit_done) begin
                    o_cmd = DP_IDLE;
                end else if (i_stat.exp_bit) begin
                    o_cmd = DP_MUL_INIT;
                end else begin
                    o_cmd = DP_SQR_INIT;
                end
            end
            S_MULA, S_MULS: begin
                o_cmd = DP_MUL_STEP;
            end
            S_WBA: begin
                o_cmd = DP_ACC_WB;
            end
            S_WBS: begin
                o_cmd = DP_PW_WB;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd = DP_RESULT;
                end
            end
            default: begin
                o_cmd = DP_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                   Word
// input     i_in_valid / o_in_stall     i_base_value, i_exponent
// output    o_out_valid / i_out_stall   o_power_residue
// config    i_cfg_we                    i_cfg_data (modulus)
//
// Each word reduces the base by the modulus, then walks the 32 exponent bits from bit 0:
// a multiply where the bit is set, then a square, both on one shared bit-serial modular multiplier.
// A modulus of 0 or 1 skips the work and returns 0.
// Synchronous reset sets the modulus to 1 and empties the output register.
// A finished word waits in the output register while the next input word is taken.

module modular_exponentiation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  mexp_pkg::t_field i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mexp_pkg::t_field i_base_value,
    input  mexp_pkg::t_field i_exponent,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output mexp_pkg::t_field o_power_residue
);
    import mexp_pkg::*;

    t_dp_op   cmd;
    t_dp_stat stat;

    mexp_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mexp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_base_value    (i_base_value),
        .i_exponent      (i_exponent),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_power_residue (o_power_residue)
    );

endmodule
